// ----- hdl/isp_pkg.sv -----
// Shared types and constants of the island scan path generator.
package isp_pkg;

  // Widths of the configuration registers.
  localparam int FIELD_BITS     = 20;
  localparam int STEP_BITS      = 16;
  localparam int TOL_BITS       = 8;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 8;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_LENGTH    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HATCH_PITCH    = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ISLAND_SIZE    = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_X_MAX    = 8'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_Y_MAX    = 8'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_X_MIN    = 8'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_Y_MIN    = 8'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_TOLERANCE = 8'd7;

  // Register values after reset.
  localparam logic [STEP_BITS-1:0]  RST_STEP_LENGTH    = 16'd10;
  localparam logic [STEP_BITS-1:0]  RST_HATCH_PITCH    = 16'd100;
  localparam logic [FIELD_BITS-1:0] RST_ISLAND_SIZE    = 20'd5000;
  localparam logic [FIELD_BITS-1:0] RST_FIELD_X_MAX    = 20'd20000;
  localparam logic [FIELD_BITS-1:0] RST_FIELD_Y_MAX    = 20'd20000;
  localparam logic [FIELD_BITS-1:0] RST_FIELD_X_MIN    = 20'd0;
  localparam logic [FIELD_BITS-1:0] RST_FIELD_Y_MIN    = 20'd0;
  localparam logic [TOL_BITS-1:0]   RST_EDGE_TOLERANCE = 8'd0;

  typedef struct packed {
    logic [STEP_BITS-1:0]  step_length;
    logic [STEP_BITS-1:0]  hatch_pitch;
    logic [FIELD_BITS-1:0] island_size;
    logic [FIELD_BITS-1:0] field_x_max;
    logic [FIELD_BITS-1:0] field_y_max;
    logic [FIELD_BITS-1:0] field_x_min;
    logic [FIELD_BITS-1:0] field_y_min;
    logic [TOL_BITS-1:0]   edge_tolerance;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic div_init_a;  // load divider with field_x_max / island_size
    logic div_step;    // one restoring division step
    logic div_init_b;  // latch row width, load divider with island / row width
    logic mul_load;    // latch column and the products of column and row with the size
    logic ph1_load;    // latch the spot after the line step and turn check
    logic ph2_load;    // apply the island change and update the scan state
    logic out_load;    // copy the scan state into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;    // the divider runs its final step in this cycle
  } stat_t;

endpackage

// ----- hdl/isp_cfg.sv -----
// Configuration register file of the island scan path generator.
module isp_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [isp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [isp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output isp_pkg::cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_length    <= isp_pkg::RST_STEP_LENGTH;
      cfg.hatch_pitch    <= isp_pkg::RST_HATCH_PITCH;
      cfg.island_size    <= isp_pkg::RST_ISLAND_SIZE;
      cfg.field_x_max    <= isp_pkg::RST_FIELD_X_MAX;
      cfg.field_y_max    <= isp_pkg::RST_FIELD_Y_MAX;
      cfg.field_x_min    <= isp_pkg::RST_FIELD_X_MIN;
      cfg.field_y_min    <= isp_pkg::RST_FIELD_Y_MIN;
      cfg.edge_tolerance <= isp_pkg::RST_EDGE_TOLERANCE;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes past the last register are dropped.
      case (cfg_index)
        isp_pkg::REG_STEP_LENGTH:    cfg.step_length    <= cfg_data[isp_pkg::STEP_BITS-1:0];
        isp_pkg::REG_HATCH_PITCH:    cfg.hatch_pitch    <= cfg_data[isp_pkg::STEP_BITS-1:0];
        isp_pkg::REG_ISLAND_SIZE:    cfg.island_size    <= cfg_data[isp_pkg::FIELD_BITS-1:0];
        isp_pkg::REG_FIELD_X_MAX:    cfg.field_x_max    <= cfg_data[isp_pkg::FIELD_BITS-1:0];
        isp_pkg::REG_FIELD_Y_MAX:    cfg.field_y_max    <= cfg_data[isp_pkg::FIELD_BITS-1:0];
        isp_pkg::REG_FIELD_X_MIN:    cfg.field_x_min    <= cfg_data[isp_pkg::FIELD_BITS-1:0];
        isp_pkg::REG_FIELD_Y_MIN:    cfg.field_y_min    <= cfg_data[isp_pkg::FIELD_BITS-1:0];
        isp_pkg::REG_EDGE_TOLERANCE: cfg.edge_tolerance <= cfg_data[isp_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/isp_ctrl.sv -----
// Sequencing state machine of the island scan path generator.
module isp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           tick,
  output logic           out_valid,
  input  logic           out_ready,
  input  isp_pkg::stat_t stat,
  output isp_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVA = 3'd1;
  localparam logic [2:0] ST_SETB = 3'd2;
  localparam logic [2:0] ST_DIVB = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_PH1  = 3'd5;
  localparam logic [2:0] ST_PH2  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (tick) begin
            cmd.div_init_a = 1'b1;
            state_next     = ST_DIVA;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_DIVA: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_SETB;
      end
      ST_SETB: begin
        cmd.div_init_b = 1'b1;
        state_next     = ST_DIVB;
      end
      ST_DIVB: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_PH1;
      end
      ST_PH1: begin
        cmd.ph1_load = 1'b1;
        state_next   = ST_PH2;
      end
      ST_PH2: begin
        cmd.ph2_load = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("second transfer taken while an item is in work");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transfer");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> slot_free)
    else $error("output register overwritten while a result waits");
  a_div_chain: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVA && stat.div_last |=> cmd.div_init_b)
    else $error("row width division did not hand over to island division");
`endif

endmodule

// ----- hdl/isp_datapath.sv -----
// Divider, multipliers, scan state and output register of the path generator.
module isp_datapath #(
  parameter int COORD_BITS  = 20,
  parameter int ISLAND_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  isp_pkg::cfg_t          cfg,
  input  isp_pkg::cmd_t          cmd,
  output isp_pkg::stat_t         stat,
  output logic [COORD_BITS-1:0]  out_spot_x,
  output logic [COORD_BITS-1:0]  out_spot_y,
  output logic [ISLAND_BITS-1:0] out_island_number,
  output logic                   out_going_reverse
);

  localparam int FB       = isp_pkg::FIELD_BITS;
  localparam int LEN_BITS = (COORD_BITS > FB) ? COORD_BITS : FB;
  localparam int DIV_BITS = (LEN_BITS > ISLAND_BITS) ? LEN_BITS : ISLAND_BITS;
  localparam int DIV_W1   = DIV_BITS + 1;
  localparam int CNT_BITS = $clog2(DIV_BITS + 1);
  localparam int PW       = ISLAND_BITS + FB;
  localparam int SW       = ISLAND_BITS + LEN_BITS + 3;

  // Scan state.
  logic [COORD_BITS-1:0]  spot_x;
  logic [COORD_BITS-1:0]  spot_y;
  logic [COORD_BITS-1:0]  start_x;
  logic [COORD_BITS-1:0]  start_y;
  logic [ISLAND_BITS-1:0] island;
  logic                   reverse;

  // Divider.
  logic [DIV_BITS-1:0] div_rem;
  logic [DIV_BITS-1:0] div_quo;
  logic [DIV_BITS-1:0] div_den;
  logic [CNT_BITS-1:0] div_cnt;
  logic [DIV_BITS:0]   div_trial;
  logic [DIV_BITS:0]   div_diff;
  logic                div_ge;

  logic [FB-1:0]          size_eff;
  logic [DIV_BITS-1:0]    rowx_ceil;
  logic [DIV_BITS-1:0]    rowx_calc;
  logic [DIV_BITS-1:0]    rowx;
  logic [ISLAND_BITS-1:0] col;
  logic [PW-1:0]          col_size;
  logic [PW-1:0]          row_size;

  // Spot after the line step.
  logic signed [SW-1:0] ph_x;
  logic signed [SW-1:0] ph_y;
  logic                 ph_rev;
  logic signed [SW-1:0] ph_x_c;
  logic signed [SW-1:0] ph_y_c;
  logic                 ph_rev_c;

  logic signed [SW-1:0] sx_p1x, sx_p1y, sx_refx, sx_refy;
  logic signed [SW-1:0] sx_step, sx_hatch, sx_eps, sx_size;
  logic signed [SW-1:0] sx_xmax, sx_ymax, sx_xmin, sx_ymin;
  logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [SW-1:0] x_inc, x_dec, y_inc, y_dec;
  logic                 turn;

  logic                   edge_x, edge_y, moved, new_row;
  logic [ISLAND_BITS-1:0] island_inc;
  logic [ISLAND_BITS-1:0] island_adv;
  logic signed [SW-1:0]   fin_x, fin_y;
  logic [COORD_BITS-1:0]  sat_x, sat_y;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[SW-1]) begin
      r = '0;
    end else if (|v[SW-2:COORD_BITS]) begin
      r = '1;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign size_eff = (cfg.island_size == '0) ? FB'(1) : cfg.island_size;

  // Restoring divider, one quotient bit a cycle.
  assign div_trial     = {div_rem, div_quo[DIV_BITS-1]};
  assign div_diff      = div_trial - DIV_W1'(div_den);
  assign div_ge        = (div_trial >= DIV_W1'(div_den));
  assign stat.div_last = (div_cnt == CNT_BITS'(1));

  // Islands per row: ceiling of the quotient, at least one.
  assign rowx_ceil = div_quo + DIV_BITS'(div_rem != '0);
  assign rowx_calc = (rowx_ceil == '0) ? DIV_BITS'(1) : rowx_ceil;

  always_ff @(posedge clk) begin
    if (cmd.div_init_a) begin
      div_rem <= '0;
      div_quo <= DIV_BITS'(cfg.field_x_max);
      div_den <= DIV_BITS'(size_eff);
      div_cnt <= CNT_BITS'(DIV_BITS);
    end else if (cmd.div_init_b) begin
      rowx    <= rowx_calc;
      div_rem <= '0;
      div_quo <= DIV_BITS'(island);
      div_den <= rowx_calc;
      div_cnt <= CNT_BITS'(DIV_BITS);
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_diff[DIV_BITS-1:0] : div_trial[DIV_BITS-1:0];
      div_quo <= {div_quo[DIV_BITS-2:0], div_ge};
      div_cnt <= div_cnt - CNT_BITS'(1);
    end
    if (cmd.mul_load) begin
      col      <= div_rem[ISLAND_BITS-1:0];
      col_size <= PW'(div_rem[ISLAND_BITS-1:0]) * PW'(size_eff);
      row_size <= PW'(div_quo[ISLAND_BITS-1:0]) * PW'(size_eff);
    end
  end

  assign sx_p1x   = $signed(SW'(spot_x));
  assign sx_p1y   = $signed(SW'(spot_y));
  assign sx_refx  = $signed(SW'(start_x));
  assign sx_refy  = $signed(SW'(start_y));
  assign sx_step  = $signed(SW'(cfg.step_length));
  assign sx_hatch = $signed(SW'(cfg.hatch_pitch));
  assign sx_eps   = $signed(SW'(cfg.edge_tolerance));
  assign sx_size  = $signed(SW'(size_eff));
  assign sx_xmax  = $signed(SW'(cfg.field_x_max));
  assign sx_ymax  = $signed(SW'(cfg.field_y_max));
  assign sx_xmin  = $signed(SW'(cfg.field_x_min));
  assign sx_ymin  = $signed(SW'(cfg.field_y_min));

  // Edges of the current island.
  assign lo_x = $signed(SW'(col_size));
  assign hi_x = lo_x + sx_size;
  assign lo_y = $signed(SW'(row_size));
  assign hi_y = lo_y + sx_size;

  assign x_inc = sx_p1x + sx_step;
  assign x_dec = sx_p1x - sx_step;
  assign y_inc = sx_p1y + sx_step;
  assign y_dec = sx_p1y - sx_step;

  // Line step and turn at a line end.
  always_comb begin
    turn     = 1'b0;
    ph_x_c   = sx_p1x;
    ph_y_c   = sx_p1y;
    ph_rev_c = reverse;
    case ({island[0], reverse})
      2'b00: begin
        turn     = (hi_x + sx_eps < x_inc) || (sx_xmax + sx_eps < x_inc);
        ph_x_c   = turn ? sx_p1x : x_inc;
        ph_y_c   = turn ? sx_p1y + sx_hatch : sx_p1y;
        ph_rev_c = turn;
      end
      2'b01: begin
        turn     = (x_dec < lo_x - sx_eps) || (x_dec < sx_xmin - sx_eps);
        ph_x_c   = turn ? sx_refx : x_dec;
        ph_y_c   = turn ? sx_p1y + sx_hatch : sx_p1y;
        ph_rev_c = !turn;
      end
      2'b10: begin
        turn     = (hi_y + sx_eps < y_inc) || (sx_ymax + sx_eps < y_inc);
        ph_x_c   = turn ? sx_p1x + sx_hatch : sx_p1x;
        ph_y_c   = turn ? sx_p1y : y_inc;
        ph_rev_c = turn;
      end
      2'b11: begin
        turn     = (y_dec < lo_y - sx_eps) || (y_dec < sx_ymin - sx_eps);
        ph_x_c   = turn ? sx_p1x + sx_hatch : sx_p1x;
        ph_y_c   = turn ? sx_refy : y_dec;
        ph_rev_c = !turn;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ph1_load) begin
      ph_x   <= ph_x_c;
      ph_y   <= ph_y_c;
      ph_rev <= ph_rev_c;
    end
  end

  // Island change: even islands leave across y, odd ones across x.
  assign edge_x = (hi_x + sx_eps < ph_x) || (sx_xmax + sx_eps < ph_x);
  assign edge_y = (hi_y + sx_eps < ph_y) || (sx_ymax + sx_eps < ph_y);
  assign moved  = island[0] ? edge_x : edge_y;

  // A new row starts when the counter wraps or the next column reaches the row width.
  assign island_inc = island + ISLAND_BITS'(1);
  assign new_row    = (island_inc == '0) || (DIV_W1'(col) + DIV_W1'(1) == DIV_W1'(rowx));
  assign island_adv = (new_row && island_inc[0]) ? island_inc + ISLAND_BITS'(1) : island_inc;

  always_comb begin
    fin_x = ph_x;
    fin_y = ph_y;
    if (moved) begin
      if (new_row) begin
        fin_x = sx_xmin;
        fin_y = hi_y + sx_hatch;
      end else begin
        fin_x = (!island[0] && reverse) ? hi_x + sx_hatch : sx_p1x + sx_hatch;
        fin_y = sx_refy;
      end
    end
  end

  assign sat_x = sat_coord(fin_x);
  assign sat_y = sat_coord(fin_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      spot_x  <= COORD_BITS'(isp_pkg::RST_FIELD_X_MIN);
      spot_y  <= COORD_BITS'(isp_pkg::RST_FIELD_Y_MIN);
      start_x <= COORD_BITS'(isp_pkg::RST_FIELD_X_MIN);
      start_y <= COORD_BITS'(isp_pkg::RST_FIELD_Y_MIN);
      island  <= '0;
      reverse <= 1'b0;
    end else if (cmd.ph2_load) begin
      spot_x <= sat_x;
      spot_y <= sat_y;
      if (moved) begin
        start_x <= sat_x;
        start_y <= sat_y;
        island  <= island_adv;
        reverse <= 1'b0;
      end else begin
        reverse <= ph_rev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_spot_x        <= spot_x;
      out_spot_y        <= spot_y;
      out_island_number <= island;
      out_going_reverse <= reverse;
    end
  end

endmodule

// ----- hdl/island_scan_path_generator.sv -----
// Top level of the island scan path generator: stream ports, config port, submodules.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tick in s_axis_tdata[0]
//   m_axis    out        m_axis_tvalid / m_axis_tready  spot, island, direction
//   cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A transfer with tick = 1 runs two divisions on the shared restoring divider of width
// D = max(COORD_BITS, 20, ISLAND_BITS), one for the islands per row and one for column
// and row of the current island, then the line step and the island change.
// A transfer with tick = 0 reports the current state without a new step.
// No new transfer is accepted until the result of the current one is loaded.
// Reset is synchronous and puts the spot at the lower field corner in island zero.
// The configuration port is always ready. When a result waits on m_axis, the finished
// next result stays in the scan state until the output register is free.
module island_scan_path_generator #(
  parameter int COORD_BITS  = 20,
  parameter int ISLAND_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream; fields from bit 0 up: tick (1), zero padding (7).
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,
  // Output stream; fields from bit 0 up: spot_x (COORD_BITS), spot_y (COORD_BITS),
  // island_number (ISLAND_BITS), going_reverse (1), zero padding to whole bytes.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((2 * COORD_BITS + ISLAND_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [isp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [isp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int FIELDS_BITS = 2 * COORD_BITS + ISLAND_BITS + 1;
  localparam int OUT_BITS    = ((FIELDS_BITS + 7) / 8) * 8;

  isp_pkg::cfg_t  cfg;
  isp_pkg::cmd_t  cmd;
  isp_pkg::stat_t stat;

  logic [COORD_BITS-1:0]  out_spot_x;
  logic [COORD_BITS-1:0]  out_spot_y;
  logic [ISLAND_BITS-1:0] out_island_number;
  logic                   out_going_reverse;

  isp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The controller owns both handshakes and the output valid flag.
  isp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .tick      (s_axis_tdata[0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  isp_datapath #(
    .COORD_BITS  (COORD_BITS),
    .ISLAND_BITS (ISLAND_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .stat              (stat),
    .out_spot_x        (out_spot_x),
    .out_spot_y        (out_spot_y),
    .out_island_number (out_island_number),
    .out_going_reverse (out_going_reverse)
  );

  // Pack the result fields from the lowest bit up and pad with zeros.
  assign m_axis_tdata = OUT_BITS'({out_going_reverse, out_island_number,
                                   out_spot_y, out_spot_x});

endmodule
